/* src/assert_macros.svh */
// assertion helpers used by the top-level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/adsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pkg
// shared types, constants and helpers of the envelope level core
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int LEN_W   = 20;
    localparam int LVL_W   = 16;
    localparam int CURVE_W = 15;
    localparam int DIV_W   = 48;   // dividend width of every division
    localparam int DEN_W   = 34;   // divisor width
    localparam int QUO_W   = 17;   // quotient width, all quotients stay below 2^17
    localparam logic [LVL_W-1:0] ONE_Q15 = 16'd32768;

    typedef enum logic [2:0] {
        REG_ATTACK  = 3'd0,
        REG_DECAY   = 3'd1,
        REG_RELEASE = 3'd2,
        REG_SUSTAIN = 3'd3,
        REG_CURVE   = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        SEG_ATTACK  = 2'd0,
        SEG_DECAY   = 2'd1,
        SEG_RELEASE = 2'd2,
        SEG_END     = 2'd3
    } seg_t;

    // kind of arithmetic the back end does
    typedef enum logic [2:0] {
        OP_ZERO,      // level 0, no division
        OP_LINEAR,    // level = n*32768/A
        OP_CURVE,     // exponent division then exp2 ratio
        OP_DECAY,     // 32768 - (32768-S)*j/D
        OP_RELEASE    // S - S*k/R
    } op_t;

    typedef struct packed {
        op_t              op;
        seg_t             seg;
        logic             empty;
        logic [DIV_W-1:0] num;   // first dividend
        logic [DEN_W-1:0] den;   // first divisor
        logic [LVL_W-1:0] base;  // offset for decay and release
        logic [QUO_W-1:0] big;   // 2*L for the curve
    } cmd_t;

    // 2^(k/16) in q16
    function automatic logic [17:0] exp2_tab(input logic [4:0] k);
        logic [17:0] v;
        case (k)
            5'd0:  v = 18'd65536;
            5'd1:  v = 18'd68438;
            5'd2:  v = 18'd71468;
            5'd3:  v = 18'd74632;
            5'd4:  v = 18'd77936;
            5'd5:  v = 18'd81386;
            5'd6:  v = 18'd84990;
            5'd7:  v = 18'd88752;
            5'd8:  v = 18'd92682;
            5'd9:  v = 18'd96785;
            5'd10: v = 18'd101070;
            5'd11: v = 18'd105545;
            5'd12: v = 18'd110218;
            5'd13: v = 18'd115098;
            5'd14: v = 18'd120194;
            5'd15: v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    // exp2 of a q12 exponent in q16, minus one
    function automatic logic [DEN_W-1:0] exp2_m1(input logic [QUO_W-1:0] x);
        logic [3:0]  ip;
        logic [3:0]  k;
        logic [7:0]  fr;
        logic [17:0] lo;
        logic [17:0] hi;
        logic [25:0] prod;
        logic [17:0] m;
        logic [DEN_W-1:0] sh;
        ip   = x[15:12];
        k    = x[11:8];
        fr   = x[7:0];
        lo   = exp2_tab({1'b0, k});
        hi   = exp2_tab({1'b0, k} + 5'd1);
        prod = (hi - lo) * fr;
        m    = lo + prod[25:8];
        sh   = {{(DEN_W-18){1'b0}}, m} << ip;
        return sh - DEN_W'(65536);
    endfunction

endpackage

/* src/adsr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_front
// classifies an index into a segment and forms the division operands
// ----------------------------------------------------------------------------
module adsr_front
    import adsr_pkg::*;
#(
    parameter int INDEX_BITS = 20
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [INDEX_BITS-1:0] n,
    input  logic [LEN_W-1:0]     a,
    input  logic [LEN_W-1:0]     d,
    input  logic [LEN_W-1:0]     r,
    input  logic [LVL_W-1:0]     s_raw,
    input  logic [CURVE_W-1:0]   curve,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    logic [21:0] tot;
    logic [21:0] ad;
    logic [21:0] nx;
    logic [LVL_W-1:0] s;
    logic [21:0] j;
    logic [21:0] k;
    cmd_t cmd_next;
    cmd_t cmd_reg;
    logic valid_reg;

    always_comb
    begin
        nx  = 22'(n);
        ad  = 22'(a) + 22'(d);
        tot = ad + 22'(r);
        s   = (s_raw > ONE_Q15) ? ONE_Q15 : s_raw;
        j   = nx - 22'(a);
        k   = nx - ad;
        cmd_next = '0;
        cmd_next.op  = OP_ZERO;
        cmd_next.seg = SEG_END;
        cmd_next.big = {1'b0, curve, 1'b0};
        if (tot == '0)
        begin
            cmd_next.empty = 1'b1;
        end
        else if (nx < 22'(a))
        begin
            cmd_next.seg = SEG_ATTACK;
            cmd_next.den = DEN_W'(a);
            if (curve != '0)
            begin
                cmd_next.op  = OP_CURVE;
                cmd_next.num = DIV_W'({curve, 1'b0}) * DIV_W'(n);
            end
            else
            begin
                cmd_next.op  = OP_LINEAR;
                cmd_next.num = DIV_W'(n) << 15;
            end
        end
        else if (nx < ad)
        begin
            cmd_next.seg  = SEG_DECAY;
            cmd_next.op   = OP_DECAY;
            cmd_next.den  = DEN_W'(d);
            cmd_next.base = ONE_Q15;
            cmd_next.num  = DIV_W'(ONE_Q15 - s) * DIV_W'(j);
        end
        else if (nx < tot)
        begin
            cmd_next.seg  = SEG_RELEASE;
            cmd_next.op   = OP_RELEASE;
            cmd_next.den  = DEN_W'(r);
            cmd_next.base = s;
            cmd_next.num  = DIV_W'(s) * DIV_W'(k);
        end
    end

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

/* src/adsr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module adsr_div
    import adsr_pkg::*;
#(
    parameter int TAG_W = 8
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DIV_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo,
    output logic [TAG_W-1:0] tag_out
);

    // quotient fits QUO_W bits, so QUO_W stages suffice
    localparam int ST = QUO_W;
    localparam int CW = DIV_W + QUO_W;

    logic             v_reg   [1:ST];
    logic [DIV_W-1:0] rem_reg [1:ST];
    logic [DEN_W-1:0] den_reg [1:ST];
    logic [QUO_W-1:0] q_reg   [1:ST];
    logic [TAG_W-1:0] tag_reg [1:ST];

    genvar g;
    generate
        for (g = 0; g < ST; g++)
        begin : g_st
            localparam int SH = ST - 1 - g;
            logic             v_i;
            logic [DIV_W-1:0] rem_i;
            logic [DEN_W-1:0] den_i;
            logic [QUO_W-1:0] q_i;
            logic [TAG_W-1:0] tag_i;
            logic [CW-1:0]    dsh;
            logic             ge;
            if (g == 0)
            begin : g_first
                assign v_i   = in_valid;
                assign rem_i = num;
                assign den_i = den;
                assign q_i   = '0;
                assign tag_i = tag_in;
            end
            else
            begin : g_rest
                assign v_i   = v_reg[g];
                assign rem_i = rem_reg[g];
                assign den_i = den_reg[g];
                assign q_i   = q_reg[g];
                assign tag_i = tag_reg[g];
            end
            assign dsh = CW'(den_i) << SH;
            assign ge  = CW'(rem_i) >= dsh;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[g+1] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[g+1] <= v_i;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g+1] <= ge ? rem_i - dsh[DIV_W-1:0] : rem_i;
                    q_reg[g+1]   <= q_i | (ge ? QUO_W'(1) << SH : '0);
                    den_reg[g+1] <= den_i;
                    tag_reg[g+1] <= tag_i;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[ST];
    assign quo       = q_reg[ST];
    assign tag_out   = tag_reg[ST];

endmodule

/* src/adsr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_back
// divides, evaluates the curve and finishes the level
// ----------------------------------------------------------------------------
module adsr_back
    import adsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             res_valid,
    output logic [LVL_W-1:0] res_level,
    output logic [1:0]       res_seg,
    output logic             res_empty
);

    localparam int TAG_W = $bits(op_t) + 2 + 1 + LVL_W;

    typedef struct packed {
        op_t              op;
        seg_t             seg;
        logic             empty;
        logic [LVL_W-1:0] base;
    } tag_t;

    tag_t t_in;
    tag_t t1;
    tag_t t2;
    tag_t t1_reg;
    tag_t t2_in;
    logic v1;
    logic [QUO_W-1:0] q1;
    logic [QUO_W-1:0] big_d;
    logic v1_reg;
    logic [QUO_W-1:0] q1_reg;
    logic [DEN_W-1:0] ne_reg;
    logic [DEN_W-1:0] de_reg;
    logic [DIV_W-1:0] n2;
    logic [DEN_W-1:0] d2;
    logic v2;
    logic [QUO_W-1:0] q2;
    logic [LVL_W-1:0] lvl;

    assign t_in = '{op: cmd.op, seg: cmd.seg, empty: cmd.empty, base: cmd.base};

    // first division; big for the curve rides along in the divider's tag
    adsr_div #(.TAG_W(TAG_W + QUO_W)) u_div1 (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(cmd_valid), .num(cmd.num), .den(cmd.den),
        .tag_in({t_in, cmd.big}),
        .out_valid(v1), .quo(q1), .tag_out({t1, big_d})
    );

    // exp2 stage: numerator and denominator for the curve ratio
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= t1;
            q1_reg <= q1;
            ne_reg <= exp2_m1(q1);
            de_reg <= exp2_m1(big_d);
        end
    end

    always_comb
    begin
        t2_in = t1_reg;
        n2    = DIV_W'(ne_reg) << 15;
        d2    = de_reg;
        // flat curve falls back to the linear quotient
        if (t1_reg.op == OP_CURVE && de_reg == '0)
        begin
            t2_in.op = OP_LINEAR;
        end
        if (t1_reg.op != OP_CURVE || de_reg == '0)
        begin
            n2 = DIV_W'(q1_reg);
            d2 = DEN_W'(1);
        end
    end

    // second division, pass-through by one for the non curve ops
    adsr_div #(.TAG_W(TAG_W)) u_div2 (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v1_reg), .num(n2), .den(d2), .tag_in(t2_in),
        .out_valid(v2), .quo(q2), .tag_out(t2)
    );

    always_comb
    begin
        case (t2.op) inside
            OP_LINEAR, OP_CURVE: lvl = q2[LVL_W-1:0];
            OP_DECAY:            lvl = t2.base - q2[LVL_W-1:0];
            OP_RELEASE:          lvl = t2.base - q2[LVL_W-1:0];
            default:             lvl = '0;
        endcase
    end

    assign res_valid = v2;
    assign res_level = lvl;
    assign res_seg   = t2.seg;
    assign res_empty = t2.empty;

endmodule

/* src/adsr_envelope_table_value_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_table_value_core
// envelope level for a sample index, attack / decay / release
// ----------------------------------------------------------------------------
// usage
//   push a sample_index while full is low; one result per index comes back in
//   order on level, segment and empty_envelope while empty is low, and is
//   taken with pop.
//   configuration writes go over cfg_valid / cfg_ready with cfg_index and
//   cfg_data; write only while no request is in flight.
// timing
//   one request per cycle sustained while pop keeps the output queue from
//   filling. a request is taken into the front register, then passes the
//   stages of the first divider, the exp2 stage, the stages of the second
//   divider and the result queue on its way to the ports.
//   most of that path lies in the two pipelined dividers.
// reset
//   registers return to their reset values, all queues empty.
// stall
//   the back pipeline advances only when its result has room in the output
//   queue; when pop is held low the queue fills, the pipeline freezes and
//   full rises once the front register is occupied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adsr_envelope_table_value_core
    import adsr_pkg::*;
#(
    parameter int INDEX_BITS = 20
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [19:0]       sample_index,
    output logic              empty,
    input  logic              pop,
    output logic [15:0]       level,
    output logic [1:0]        segment,
    output logic              empty_envelope,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [19:0]       cfg_data
);

    // config registers
    logic [LEN_W-1:0]   attack_reg;
    logic [LEN_W-1:0]   decay_reg;
    logic [LEN_W-1:0]   release_reg;
    logic [LVL_W-1:0]   sustain_reg;
    logic [CURVE_W-1:0] curve_reg;

    logic cmd_valid;
    logic cmd_ready;
    logic cmd_in_ready;
    cmd_t cmd;
    logic en;
    logic res_valid;
    logic [LVL_W-1:0] res_level;
    logic [1:0] res_seg;
    logic res_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= LEN_W'(200);
            decay_reg   <= LEN_W'(5);
            release_reg <= LEN_W'(6000);
            sustain_reg <= ONE_Q15;
            curve_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ATTACK:  attack_reg  <= cfg_data;
                REG_DECAY:   decay_reg   <= cfg_data;
                REG_RELEASE: release_reg <= cfg_data;
                REG_SUSTAIN: sustain_reg <= cfg_data[LVL_W-1:0];
                REG_CURVE:   curve_reg   <= cfg_data[CURVE_W-1:0];
                default:     ;
            endcase
        end
    end

    // front: classify and build operands
    adsr_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(push), .in_ready(cmd_in_ready),
        .n(INDEX_BITS'(sample_index)),
        .a(attack_reg), .d(decay_reg), .r(release_reg),
        .s_raw(sustain_reg), .curve(curve_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    assign full = !cmd_in_ready;

    // output queue, two entries; the back pipeline moves when there is room
    logic [1:0] cnt_reg;
    logic       wp_reg;
    logic       rp_reg;
    logic [LVL_W+3-1:0] q_mem [2];
    logic do_pop;
    logic do_push;

    assign en        = (cnt_reg != 2'd2) || (pop && !empty);
    assign cmd_ready = en;
    assign do_push   = en && res_valid;
    assign do_pop    = pop && !empty;
    assign empty     = (cnt_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wp_reg] <= {res_level, res_seg, res_empty};
        end
    end

    assign {level, segment, empty_envelope} = q_mem[rp_reg];

    // back: dividers, exp2 and final level
    adsr_back u_back (
        .clk(clk), .rst_n(rst_n), .en(en),
        .cmd_valid(cmd_valid), .cmd(cmd),
        .res_valid(res_valid), .res_level(res_level),
        .res_seg(res_seg), .res_empty(res_empty)
    );

    `ASSERT_IMPLIES(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3)
    `ASSERT_NEXT(a_pop_drains, clk, rst_n, do_pop && !do_push, cnt_reg == $past(cnt_reg) - 2'd1)
    `ASSERT_IMPLIES(a_empty_flag, clk, rst_n, res_valid && res_empty, res_seg == SEG_END)

endmodule
